// ----- rtl/rcbm_pkg.sv -----
// Package for the rounded corner border mask block.
// Holds payload and configuration types, register indexes and constants.
// No dependencies; every other file of the block uses it.
package rcbm_pkg;

  localparam int X_W      = 10;
  localparam int Y_W      = 10;
  localparam int CH_W     = 8;
  localparam int RADIUS_W = 8;
  localparam int HEIGHT_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam int MAX_DIM_DEFAULT = 1024;

  localparam int PAD_SIZE    = 4;
  localparam int FRAME_WIDTH = 2;

  localparam logic [CH_W-1:0] FRAME_GRAY = 8'd100;
  localparam logic [CH_W-1:0] OPAQUE     = 8'd255;
  localparam logic [CH_W-1:0] CLEAR      = 8'd0;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd60;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [X_W-1:0]  pixel_x;
    logic [Y_W-1:0]  pixel_y;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_alpha;
  } rcbm_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
  } rcbm_out_t;

  // Geometry derived from the two registers, held ready for the datapath.
  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [8:0]          cx;
    logic [8:0]          cx_m2;
    logic signed [12:0]  cy;
    logic signed [11:0]  band_lo;
    logic signed [11:0]  pad_lo;
    logic [15:0]         outer2;
    logic [15:0]         inner2;
  } rcbm_cfg_t;

endpackage

// ----- rtl/rcbm_cfg.sv -----
// Configuration registers of the rounded corner border mask block.
// Stores radius and height and registers the corner geometry derived from them.
// Depends on rcbm_pkg.
module rcbm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rcbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcbm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rcbm_pkg::rcbm_cfg_t              geom
);
  import rcbm_pkg::*;

  logic [RADIUS_W-1:0] radius;
  logic [RADIUS_W-1:0] radius_next;
  logic [HEIGHT_W-1:0] height_next;
  logic [RADIUS_W-1:0] inner_mag;
  rcbm_cfg_t           geom_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    radius_next = radius;
    height_next = geom.height;
    if (rst) begin
      radius_next = RADIUS_RESET;
      height_next = HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RADIUS: radius_next = cfg_data[RADIUS_W-1:0];
        CFG_HEIGHT: height_next = cfg_data[HEIGHT_W-1:0];
        default:    radius_next = radius;
      endcase
    end
  end

  always_comb begin
    if (radius_next >= RADIUS_W'(FRAME_WIDTH)) begin
      inner_mag = radius_next - RADIUS_W'(FRAME_WIDTH);
    end else begin
      inner_mag = RADIUS_W'(FRAME_WIDTH) - radius_next;
    end
    geom_next.height  = height_next;
    geom_next.cx      = 9'(radius_next) + 9'(PAD_SIZE);
    geom_next.cx_m2   = 9'(radius_next) + 9'(PAD_SIZE - FRAME_WIDTH);
    geom_next.cy      = $signed(13'(height_next) - 13'(radius_next) - 13'(PAD_SIZE));
    geom_next.band_lo = $signed(12'(height_next) - 12'(PAD_SIZE + FRAME_WIDTH));
    geom_next.pad_lo  = $signed(12'(height_next) - 12'(PAD_SIZE));
    geom_next.outer2  = 16'(radius_next) * 16'(radius_next);
    geom_next.inner2  = 16'(inner_mag) * 16'(inner_mag);
  end

  always_ff @(posedge clk) begin
    radius <= radius_next;
    geom   <= geom_next;
  end

endmodule

// ----- rtl/rcbm_mask.sv -----
// Paint and clear decision for one pixel of the rounded corner border mask.
// Purely combinational; uses the registered geometry from rcbm_cfg.
// Depends on rcbm_pkg.
module rcbm_mask #(
  parameter int MAX_DIM = rcbm_pkg::MAX_DIM_DEFAULT
) (
  input  rcbm_pkg::rcbm_in_t  pix,
  input  rcbm_pkg::rcbm_cfg_t geom,
  output rcbm_pkg::rcbm_out_t res
);
  import rcbm_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM) + 1;
  localparam int CMP_W = (DIM_W > X_W) ? DIM_W : X_W;

  logic               in_image;
  logic               quadrant;
  logic               paint;
  logic               clear;
  logic signed [13:0] ys;
  logic signed [13:0] cy14;
  logic signed [13:0] band14;
  logic signed [13:0] pad14;
  logic signed [13:0] dy;
  logic [8:0]         dxm;
  logic [8:0]         dym;
  logic [17:0]        d2;

  always_comb begin
    ys     = $signed({4'b0, pix.pixel_y});
    cy14   = $signed({geom.cy[12], geom.cy});
    band14 = $signed({{2{geom.band_lo[11]}}, geom.band_lo});
    pad14  = $signed({{2{geom.pad_lo[11]}}, geom.pad_lo});

    in_image = (HEIGHT_W'(pix.pixel_y) < geom.height) &&
               (CMP_W'(pix.pixel_x) < CMP_W'(MAX_DIM));
    quadrant = in_image && (ys >= cy14) && (pix.pixel_x < X_W'(geom.cx));

    // Inside the quadrant both offsets stay below 260, so nine bits suffice.
    dxm = 9'(X_W'(geom.cx) - pix.pixel_x);
    dy  = ys - cy14;
    dym = dy[8:0];
    d2  = 18'(dxm) * 18'(dxm) + 18'(dym) * 18'(dym);

    paint = in_image && (
      ((pix.pixel_x >= X_W'(PAD_SIZE)) && (pix.pixel_x < X_W'(PAD_SIZE + FRAME_WIDTH)) &&
       (ys <= cy14)) ||
      ((ys >= band14) && (ys < pad14) && (pix.pixel_x >= X_W'(geom.cx_m2))) ||
      (quadrant && (d2 <= 18'(geom.outer2)) && (d2 >= 18'(geom.inner2))));

    clear = in_image && (
      (quadrant && (d2 > 18'(geom.outer2))) ||
      ((pix.pixel_x < X_W'(PAD_SIZE)) && (ys < cy14)) ||
      ((ys >= pad14) && (pix.pixel_x >= X_W'(geom.cx))));

    if (paint) begin
      res.out_red   = FRAME_GRAY;
      res.out_green = FRAME_GRAY;
      res.out_blue  = FRAME_GRAY;
      res.out_alpha = OPAQUE;
    end else begin
      res.out_red   = pix.in_red;
      res.out_green = pix.in_green;
      res.out_blue  = pix.in_blue;
      res.out_alpha = clear ? CLEAR : pix.in_alpha;
    end
  end

endmodule

// ----- rtl/rcbm_pipe.sv -----
// Two-register pipeline of the rounded corner border mask: input register,
// mask logic, result register, with stall handling. Depends on rcbm_pkg, rcbm_mask.
module rcbm_pipe #(
  parameter int MAX_DIM = rcbm_pkg::MAX_DIM_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  rcbm_pkg::rcbm_cfg_t geom,
  input  logic                in_valid,
  output logic                in_stall,
  input  rcbm_pkg::rcbm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rcbm_pkg::rcbm_out_t out_data
);
  import rcbm_pkg::*;

  logic      s1_valid;
  rcbm_in_t  s1_data;
  rcbm_out_t result;
  logic      out_ready;
  logic      s1_ready;

  rcbm_mask #(.MAX_DIM(MAX_DIM)) u_mask (
    .pix  (s1_data),
    .geom (geom),
    .res  (result)
  );

  assign out_ready = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || out_ready;
  assign in_stall  = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_data <= in_data;
    end
    if (out_ready && s1_valid) begin
      out_data <= result;
    end
  end

endmodule

// ----- rtl/rounded_corner_border_mask_core.sv -----
// Top level of the rounded corner border mask block.
// Depends on rcbm_pkg, rcbm_cfg and rcbm_pipe.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_data  (rcbm_in_t)
// out      output     out_valid / out_stall out_data (rcbm_out_t)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel item can be accepted every cycle while in_stall is low. The input register takes
// it at the accepting edge and the result register takes its result once the output is free.
// The input register and the result register sit around the mask logic, which holds two
// squarers, one add and the compares.
// Synchronous reset clears the valid flags and loads radius 60 and height 256.
// The input stalls only when both registers hold items and the output is stalled.
module rounded_corner_border_mask_core #(
  parameter int MAX_DIM = rcbm_pkg::MAX_DIM_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rcbm_pkg::rcbm_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rcbm_pkg::rcbm_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcbm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rcbm_pkg::*;

  rcbm_cfg_t geom;

  rcbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  rcbm_pipe #(.MAX_DIM(MAX_DIM)) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/rcbm_checker.sv -----
// Port-level checks for the rounded corner border mask block, bound to the top.
// Depends on rcbm_pkg and rounded_corner_border_mask_core.
module rcbm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input rcbm_pkg::rcbm_out_t out_data,
  input logic                out_valid,
  input logic                out_stall
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("Stalled result changed or vanished.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled while the output was free.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    ((in_valid && !in_stall) ##1 !out_stall) |=> out_valid)
    else $error("Accepted item did not reach the output.");

endmodule

bind rounded_corner_border_mask_core rcbm_checker u_rcbm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
